// File: design/gmd_pkg.sv
// Package for the grid maze depth-first search solver: types, constants, step tables.
`default_nettype none
package gmd_pkg;

   localparam int MAX_ROWS   = 8;
   localparam int MAX_COLS   = 8;
   localparam int GRID_CELLS = MAX_ROWS * MAX_COLS;
   localparam int ROW_W      = 3;
   localparam int COL_W      = 3;
   localparam int ADDR_W     = ROW_W + COL_W;
   localparam int SIZE_W     = 4;
   localparam int DIR_W      = 4;
   localparam int STACK_W    = ADDR_W + DIR_W;
   localparam int DEPTH_W    = 7;
   localparam int MARK_W     = 2;
   localparam int CSR_IDX_W  = 2;

   localparam logic [MARK_W-1:0] MARK_OPEN = 2'd0;
   localparam logic [MARK_W-1:0] MARK_WALL = 2'd1;
   localparam logic [MARK_W-1:0] MARK_PATH = 2'd2;
   localparam logic [MARK_W-1:0] MARK_DEAD = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 2'd1;

   localparam logic [DIR_W-1:0]  DIR_DONE = 4'd8;
   localparam logic [SIZE_W-1:0] ROWS_MAX = 4'd8;
   localparam logic [SIZE_W-1:0] COLS_MAX = 4'd8;

   typedef struct packed {
      logic cell_blocked;
      logic last_cell;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]  cell_row;
      logic [COL_W-1:0]  cell_col;
      logic [MARK_W-1:0] cell_mark;
      logic              path_found;
      logic              last_result;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_START,
      ST_PROBE,
      ST_CHECK,
      ST_POP,
      ST_REPORT,
      ST_FLUSH
   } state_type;

   // row offset per direction, 4-bit two's complement
   function automatic logic [3:0] step_row(input logic [2:0] d);
      logic [3:0] res;
      case (d) inside
         3'd0, 3'd1, 3'd2: res = 4'd1;
         3'd3, 3'd4:       res = 4'd0;
         default:          res = 4'hF;
      endcase
      return res;
   endfunction

   // column offset per direction, 4-bit two's complement
   function automatic logic [3:0] step_col(input logic [2:0] d);
      logic [3:0] res;
      case (d) inside
         3'd0, 3'd3, 3'd5: res = 4'hF;
         3'd1, 3'd6:       res = 4'd0;
         default:          res = 4'd1;
      endcase
      return res;
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] res;
      if (v == '0) begin
         res = 4'd1;
      end else if (v > maxv) begin
         res = maxv;
      end else begin
         res = v;
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// File: design/gmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: design/grid_maze_dfs_solver.sv
// Grid maze solver top level: cell load, depth-first search and mark report.
//
//   channel | ports                          | transaction
//   --------+--------------------------------+------------------------------------
//   request | start, busy, req_data          | start & !busy: one grid cell
//   result  | rsp_valid, rsp_data            | rsp_valid high: one cell report
//   config  | csr_valid, csr_ready, csr_*    | csr_valid & csr_ready: one register
//
// Cells load one per cycle while busy is low. A last cell starts the search: each
// direction tried is probed, then checked after a mark memory read when the neighbor
// lies inside the grid; a backtrack passes a pop state (stack memory read). The report
// then streams rows*cols results, one per cycle, registered behind the mark memory reads.
// A register write while idle recomputes the load row and column from the load count by
// repeated subtraction, busy until done. Reset needs no clearing pass.
// Results cannot be stalled.
`default_nettype none
module grid_maze_dfs_solver (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire gmd_pkg::req_type           req_data,
   output logic                            rsp_valid,
   output gmd_pkg::rsp_type                rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [gmd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [gmd_pkg::SIZE_W-1:0] csr_data
);

   import gmd_pkg::*;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]   rows_ff, rows_in;
   logic [SIZE_W-1:0]   cols_ff, cols_in;
   logic [DEPTH_W-1:0]  load_pos_ff, load_pos_in;
   logic [DEPTH_W-1:0]  load_row_ff, load_row_in;
   logic [COL_W-1:0]    load_col_ff, load_col_in;
   logic [DEPTH_W-1:0]  norm_rem_ff, norm_rem_in;
   logic                found_ff, found_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [ADDR_W-1:0]   top_cell_ff, top_cell_in;
   logic [DIR_W-1:0]    top_dir_ff, top_dir_in;
   logic [ADDR_W-1:0]   nb_cell_ff, nb_cell_in;
   logic [GRID_CELLS-1:0] valid_ff, valid_in;
   logic                mark_vld_ff;
   logic [ROW_W-1:0]    rpt_row_ff, rpt_row_in;
   logic [COL_W-1:0]    rpt_col_ff, rpt_col_in;
   logic                pend_vld_ff, pend_vld_in;
   logic [ROW_W-1:0]    pend_row_ff;
   logic [COL_W-1:0]    pend_col_ff;
   logic                pend_found_ff;
   logic                pend_last_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic                mark_we;
   logic [ADDR_W-1:0]   mark_waddr;
   logic [MARK_W-1:0]   mark_wdata;
   logic [ADDR_W-1:0]   mark_raddr;
   logic [MARK_W-1:0]   mark_q;
   logic [MARK_W-1:0]   mark_cur;

   logic                stk_we;
   logic [ADDR_W-1:0]   stk_waddr;
   logic [STACK_W-1:0]  stk_wdata;
   logic [ADDR_W-1:0]   stk_raddr;
   logic [STACK_W-1:0]  stk_q;

   logic                accept;
   logic                csr_wr;
   logic                load_ok;
   logic [DEPTH_W-1:0]  pos_after_load;
   logic [3:0]          nb_row;
   logic [3:0]          nb_col;
   logic                nb_out;
   logic                nb_goal;
   logic                rpt_last;

   gmd_ram #(.WIDTH(MARK_W), .DEPTH(GRID_CELLS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_addr (mark_raddr),
      .rd_data (mark_q)
   );

   gmd_ram #(.WIDTH(STACK_W), .DEPTH(GRID_CELLS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_q)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;
   assign csr_wr    = csr_valid & csr_ready;
   assign load_ok   = (load_row_ff < {3'b000, rows_ff});

   assign mark_cur = mark_vld_ff ? mark_q : MARK_WALL;

   assign nb_row  = {1'b0, top_cell_ff[ADDR_W-1:COL_W]} + step_row(top_dir_ff[2:0]);
   assign nb_col  = {1'b0, top_cell_ff[COL_W-1:0]} + step_col(top_dir_ff[2:0]);
   assign nb_out  = nb_row[3] | nb_col[3] | (nb_row >= rows_ff) | (nb_col >= cols_ff);
   assign nb_goal = ({1'b0, nb_cell_ff[ADDR_W-1:COL_W]} == rows_ff - 4'd1)
                  & ({1'b0, nb_cell_ff[COL_W-1:0]} == cols_ff - 4'd1);
   assign rpt_last = ({1'b0, rpt_row_ff} == rows_ff - 4'd1)
                   & ({1'b0, rpt_col_ff} == cols_ff - 4'd1);

   always_comb begin
      state_in    = state_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      load_pos_in = load_pos_ff;
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      norm_rem_in = norm_rem_ff;
      found_in    = found_ff;
      depth_in    = depth_ff;
      top_cell_in = top_cell_ff;
      top_dir_in  = top_dir_ff;
      nb_cell_in  = nb_cell_ff;
      valid_in    = valid_ff;
      rpt_row_in  = rpt_row_ff;
      rpt_col_in  = rpt_col_ff;
      pend_vld_in = 1'b0;
      mark_we     = 1'b0;
      mark_waddr  = '0;
      mark_wdata  = MARK_WALL;
      mark_raddr  = '0;
      stk_we      = 1'b0;
      stk_waddr   = depth_ff[ADDR_W-1:0] - 6'd1;
      stk_wdata   = {top_cell_ff, top_dir_ff};
      stk_raddr   = depth_ff[ADDR_W-1:0] - 6'd2;
      pos_after_load = load_pos_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (load_ok) begin
                  mark_we     = 1'b1;
                  mark_waddr  = {load_row_ff[ROW_W-1:0], load_col_ff};
                  mark_wdata  = req_data.cell_blocked ? MARK_WALL : MARK_OPEN;
                  pos_after_load = load_pos_ff + 7'd1;
                  load_pos_in = pos_after_load;
                  if ({1'b0, load_col_ff} == cols_ff - 4'd1) begin
                     load_col_in = '0;
                     load_row_in = load_row_ff + 7'd1;
                  end else begin
                     load_col_in = load_col_ff + 3'd1;
                  end
               end
               if (req_data.last_cell) begin
                  state_in = ST_START;
               end
            end
         end
         ST_NORM: begin
            if (norm_rem_ff >= {3'b000, cols_ff}) begin
               norm_rem_in = norm_rem_ff - {3'b000, cols_ff};
               load_row_in = load_row_ff + 7'd1;
            end else begin
               load_col_in = norm_rem_ff[COL_W-1:0];
               state_in    = ST_IDLE;
            end
         end
         ST_START: begin
            mark_we    = 1'b1;
            mark_waddr = '0;
            mark_wdata = MARK_PATH;
            found_in   = 1'b0;
            if (rows_ff == 4'd1 && cols_ff == 4'd1) begin
               found_in   = 1'b1;
               rpt_row_in = '0;
               rpt_col_in = '0;
               state_in   = ST_REPORT;
            end else begin
               top_cell_in = '0;
               top_dir_in  = '0;
               depth_in    = 7'd1;
               state_in    = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (top_dir_ff == DIR_DONE) begin
               mark_we    = 1'b1;
               mark_waddr = top_cell_ff;
               mark_wdata = MARK_DEAD;
               depth_in   = depth_ff - 7'd1;
               if (depth_ff == 7'd1) begin
                  rpt_row_in = '0;
                  rpt_col_in = '0;
                  state_in   = ST_REPORT;
               end else begin
                  state_in = ST_POP;
               end
            end else begin
               top_dir_in = top_dir_ff + 4'd1;
               nb_cell_in = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
               mark_raddr = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
               if (!nb_out) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (mark_cur != MARK_OPEN) begin
               state_in = ST_PROBE;
            end else begin
               mark_we    = 1'b1;
               mark_waddr = nb_cell_ff;
               mark_wdata = MARK_PATH;
               if (nb_goal) begin
                  found_in   = 1'b1;
                  rpt_row_in = '0;
                  rpt_col_in = '0;
                  state_in   = ST_REPORT;
               end else begin
                  stk_we      = 1'b1;
                  top_cell_in = nb_cell_ff;
                  top_dir_in  = '0;
                  depth_in    = depth_ff + 7'd1;
                  state_in    = ST_PROBE;
               end
            end
         end
         ST_POP: begin
            top_cell_in = stk_q[STACK_W-1:DIR_W];
            top_dir_in  = stk_q[DIR_W-1:0];
            state_in    = ST_PROBE;
         end
         ST_REPORT: begin
            mark_raddr  = {rpt_row_ff, rpt_col_ff};
            pend_vld_in = 1'b1;
            if (rpt_last) begin
               found_in    = 1'b0;
               depth_in    = '0;
               load_pos_in = '0;
               load_row_in = '0;
               load_col_in = '0;
               state_in    = ST_FLUSH;
            end else if ({1'b0, rpt_col_ff} == cols_ff - 4'd1) begin
               rpt_col_in = '0;
               rpt_row_in = rpt_row_ff + 3'd1;
            end else begin
               rpt_col_in = rpt_col_ff + 3'd1;
            end
         end
         ST_FLUSH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (mark_we) begin
         valid_in[mark_waddr] = 1'b1;
      end
      if (state_ff == ST_REPORT && rpt_last) begin
         valid_in = '0;
      end

      // register write: update the size and, when idle or normalizing, restart row/column recovery from the load count
      if (csr_wr) begin
         if (csr_index == CSR_ROWS) begin
            rows_in = clamp_size(csr_data, ROWS_MAX);
         end else if (csr_index == CSR_COLS) begin
            cols_in = clamp_size(csr_data, COLS_MAX);
         end
         if ((state_ff == ST_IDLE && !(accept && req_data.last_cell))
             || state_ff == ST_NORM) begin
            norm_rem_in = pos_after_load;
            load_row_in = '0;
            state_in    = ST_NORM;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= ROWS_MAX;
         cols_ff      <= COLS_MAX;
         load_pos_ff  <= '0;
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         found_ff     <= 1'b0;
         depth_ff     <= '0;
         valid_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         load_pos_ff  <= load_pos_in;
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         found_ff     <= found_in;
         depth_ff     <= depth_in;
         valid_ff     <= valid_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= pend_vld_ff;
      end
      norm_rem_ff   <= norm_rem_in;
      top_cell_ff   <= top_cell_in;
      top_dir_ff    <= top_dir_in;
      nb_cell_ff    <= nb_cell_in;
      rpt_row_ff    <= rpt_row_in;
      rpt_col_ff    <= rpt_col_in;
      mark_vld_ff   <= valid_ff[mark_raddr];
      pend_row_ff   <= rpt_row_ff;
      pend_col_ff   <= rpt_col_ff;
      pend_found_ff <= found_ff;
      pend_last_ff  <= rpt_last;
      rsp_ff.cell_row    <= pend_row_ff;
      rsp_ff.cell_col    <= pend_col_ff;
      rsp_ff.cell_mark   <= mark_cur;
      rsp_ff.path_found  <= pend_found_ff;
      rsp_ff.last_result <= pend_last_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: tb/gmd_checker.sv
// Checker for the grid maze solver: tracks loads and register writes, predicts reports.
module gmd_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  gmd_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  gmd_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [gmd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gmd_pkg::SIZE_W-1:0]    csr_data,
   output int unsigned                   fail_count,
   output int unsigned                   reports_due
);

   import gmd_pkg::*;

   logic [MARK_W-1:0] maze_marks [GRID_CELLS];
   int                load_pos;
   int                rows_cfg;
   int                cols_cfg;
   rsp_type           cell_reports_q [$];
   rsp_type           want;
   logic              reached;

   function automatic int fit_size(input logic [SIZE_W-1:0] v, input int maxv);
      int res;
      if (v == '0) begin
         res = 1;
      end else if (int'(v) > maxv) begin
         res = maxv;
      end else begin
         res = int'(v);
      end
      return res;
   endfunction

   // depth-first walk from the top-left corner, neighbor order DL D DR L R UL U UR
   function automatic void solve_maze(input int rows, input int cols, output logic hit);
      int stk_pos [GRID_CELLS];
      int stk_dir [GRID_CELLS];
      int depth;
      int pos;
      int d;
      int r;
      int c;
      hit = 1'b0;
      depth = 0;
      maze_marks[0] = MARK_PATH;
      if (rows == 1 && cols == 1) begin
         hit = 1'b1;
      end else begin
         stk_pos[0] = 0;
         stk_dir[0] = 0;
         depth = 1;
      end
      while (!hit && depth > 0) begin
         pos = stk_pos[depth-1];
         d = stk_dir[depth-1];
         if (d >= 8) begin
            maze_marks[pos] = MARK_DEAD;
            depth--;
         end else begin
            stk_dir[depth-1] = d + 1;
            r = pos / MAX_COLS + ((d < 3) ? 1 : (d < 5) ? 0 : -1);
            c = pos % MAX_COLS + ((d == 0 || d == 3 || d == 5) ? -1 :
                                  (d == 1 || d == 6) ? 0 : 1);
            if (r >= 0 && c >= 0 && r < rows && c < cols &&
                maze_marks[r*MAX_COLS + c] == MARK_OPEN) begin
               maze_marks[r*MAX_COLS + c] = MARK_PATH;
               if (r == rows - 1 && c == cols - 1) begin
                  hit = 1'b1;
               end else if (depth < GRID_CELLS) begin
                  stk_pos[depth] = r*MAX_COLS + c;
                  stk_dir[depth] = 0;
                  depth++;
               end
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (maze_marks[i]) maze_marks[i] = MARK_WALL;
         load_pos = 0;
         rows_cfg = MAX_ROWS;
         cols_cfg = MAX_COLS;
         cell_reports_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (cell_reports_q.size() == 0) begin
               $display("%0t: unexpected cell report,", $time,
                        " row %0d col %0d mark %0d found %0d last %0d",
                        rsp_data.cell_row, rsp_data.cell_col, rsp_data.cell_mark,
                        rsp_data.path_found, rsp_data.last_result);
               fail_count++;
            end else begin
               want = cell_reports_q.pop_front();
               if (rsp_data.cell_row !== want.cell_row || rsp_data.cell_col !== want.cell_col ||
                   rsp_data.cell_mark !== want.cell_mark ||
                   rsp_data.path_found !== want.path_found ||
                   rsp_data.last_result !== want.last_result) begin
                  $display("%0t: cell report mismatch,", $time,
                           " expected row %0d col %0d mark %0d found %0d last %0d,",
                           want.cell_row, want.cell_col, want.cell_mark,
                           want.path_found, want.last_result,
                           " got row %0d col %0d mark %0d found %0d last %0d",
                           rsp_data.cell_row, rsp_data.cell_col, rsp_data.cell_mark,
                           rsp_data.path_found, rsp_data.last_result);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROWS) rows_cfg = fit_size(csr_data, MAX_ROWS);
            else if (csr_index == CSR_COLS) cols_cfg = fit_size(csr_data, MAX_COLS);
         end
         if (start && !busy) begin
            if (load_pos < rows_cfg * cols_cfg) begin
               maze_marks[(load_pos / cols_cfg) * MAX_COLS + load_pos % cols_cfg] =
                  req_data.cell_blocked ? MARK_WALL : MARK_OPEN;
               load_pos++;
            end
            if (req_data.last_cell) begin
               solve_maze(rows_cfg, cols_cfg, reached);
               for (int r = 0; r < rows_cfg; r++) begin
                  for (int c = 0; c < cols_cfg; c++) begin
                     want.cell_row = r[ROW_W-1:0];
                     want.cell_col = c[COL_W-1:0];
                     want.cell_mark = maze_marks[r*MAX_COLS + c];
                     want.path_found = reached;
                     want.last_result = (r == rows_cfg - 1 && c == cols_cfg - 1);
                     cell_reports_q.push_back(want);
                  end
               end
               foreach (maze_marks[i]) maze_marks[i] = MARK_WALL;
               load_pos = 0;
            end
         end
      end
      reports_due = cell_reports_q.size();
   end

endmodule

// File: tb/tb_grid_maze_dfs_solver.sv
// Testbench top for the grid maze solver: clock, reset, grid and register stimulus, verdict.
module tb_grid_maze_dfs_solver;
   import gmd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   req_type              req_data = '0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_ROWS;
   logic [SIZE_W-1:0]    csr_data = '0;
   logic                 busy;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_ready;
   int unsigned          fail_count;
   int unsigned          reports_due;
   int                   idle_pct = 0;

   grid_maze_dfs_solver DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   gmd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .reports_due (reports_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #40000000;
      $display("status: fail");
      $finish;
   end

   task automatic load_cell(input logic blocked, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data.cell_blocked <= blocked;
      req_data.last_cell <= last;
      do @(posedge clock); while (busy);
   endtask

   // sends cells first..count-1 of a wall map, last flag on the final one
   task automatic send_grid(input logic [63:0] walls, input int first, input int count);
      for (int k = first; k < count; k++) load_cell(walls[k[5:0]], k == count - 1);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      start <= 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
      @(negedge clock);
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
      wait_quiet();
      write_reg(CSR_ROWS, rows);
      write_reg(CSR_COLS, cols);
   endtask

   function automatic logic [SIZE_W-1:0] pick_size();
      int roll;
      logic [SIZE_W-1:0] res;
      roll = $urandom_range(99);
      if (roll < 5) res = 4'd0;
      else if (roll < 10) res = 4'($urandom_range(15, 9));
      else if (roll < 22) res = 4'd8;
      else res = 4'($urandom_range(4, 1));
      return res;
   endfunction

   initial begin
      logic [SIZE_W-1:0] rows_raw;
      logic [SIZE_W-1:0] cols_raw;
      logic [63:0]       walls;
      int                cells;
      int                n_send;
      int                split;
      int                wall_pct;
      int                kind;
      int                sent;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single blocked cell: start is the goal
      set_size(4'd0, 4'd0);
      write_reg(CSR_SPARE_A, 4'd15);
      write_reg(CSR_SPARE_B, 4'd10);
      send_grid(64'h1, 0, 1);
      // one row, extra cell past the end is dropped
      set_size(4'd1, 4'd3);
      send_grid(64'h8, 0, 4);
      // grid ends after two cells, rest stays walls
      set_size(4'd2, 4'd2);
      send_grid(64'h0, 0, 2);
      // blocked start, open elsewhere
      send_grid(64'h1, 0, 4);
      // width changes in the middle of a load
      load_cell(1'b0, 1'b0);
      load_cell(1'b0, 1'b0);
      wait_quiet();
      write_reg(CSR_COLS, 4'd3);
      send_grid(64'h0, 2, 4);
      // tall column with a wall across it: no path, dead ends behind
      set_size(4'd9, 4'd1);
      send_grid(64'h10, 0, 8);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            1:       idle_pct = 63;
            3:       idle_pct = 33;
            default: idle_pct = 0;
         endcase
         sent = 0;
         rows_raw = pick_size();
         cols_raw = pick_size();
         set_size(rows_raw, cols_raw);
         while (sent < 105) begin
            if ($urandom_range(3) == 0) begin
               rows_raw = pick_size();
               cols_raw = pick_size();
               set_size(rows_raw, cols_raw);
               if ($urandom_range(9) == 0)
                  write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, 4'($urandom));
            end
            cells = ((rows_raw == 0) ? 1 : (rows_raw > 8) ? 8 : int'(rows_raw)) *
                    ((cols_raw == 0) ? 1 : (cols_raw > 8) ? 8 : int'(cols_raw));
            wall_pct = $urandom_range(50);
            for (int k = 0; k < 64; k++) walls[k] = ($urandom_range(99) < wall_pct);
            kind = $urandom_range(99);
            if (kind < 80) n_send = cells;
            else if (kind < 90) n_send = $urandom_range(cells, 1);
            else n_send = cells + $urandom_range(3, 1);
            if (kind >= 95 && n_send > 1) begin
               split = $urandom_range(n_send - 1, 1);
               for (int k = 0; k < split; k++) load_cell(walls[k[5:0]], 1'b0);
               wait_quiet();
               if ($urandom_range(1)) begin
                  rows_raw = pick_size();
                  write_reg(CSR_ROWS, rows_raw);
               end else begin
                  cols_raw = pick_size();
                  write_reg(CSR_COLS, cols_raw);
               end
               send_grid(walls, split, n_send);
            end else begin
               send_grid(walls, 0, n_send);
            end
            sent += n_send;
         end
      end

      @(negedge clock);
      start <= 1'b0;
      while (reports_due != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0 && reports_due == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: files.f
design/gmd_pkg.sv
design/gmd_ram.sv
design/grid_maze_dfs_solver.sv
tb/gmd_checker.sv
tb/tb_grid_maze_dfs_solver.sv
